### hdl/onenc_pkg.sv
// shared constants for the octahedral normal encoder
// no dependencies; imported by the front end and the top level
`default_nettype none

package onenc_pkg;

   // register stages ahead of the divider: magnitude, fold, numerator
   localparam int FRONT_STAGES = 3;

endpackage

`default_nettype wire

### hdl/onenc_ifs.sv
// valid/ready channel interfaces for the octahedral normal encoder
// request carries the direction vector, response the two unorm coordinates
`default_nettype none

interface onenc_req_if #(
   parameter int IN_BITS = 16
);
   logic                      valid;
   logic                      ready;
   logic signed [IN_BITS-1:0] vec_x;
   logic signed [IN_BITS-1:0] vec_y;
   logic signed [IN_BITS-1:0] vec_z;

   modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface onenc_rsp_if #(
   parameter int OUT_BITS = 16
);
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] oct_u;
   logic [OUT_BITS-1:0] oct_v;

   modport source (output valid, output oct_u, output oct_v, input ready);
   modport sink   (input valid, input oct_u, input oct_v, output ready);
endinterface

`default_nettype wire

### hdl/octahedral_normal_encode_core.sv
// octahedral normal encoder
//
// request channel (req_chan): one direction vector vec_x/vec_y/vec_z, signed
// fixed point, IN_BITS wide. response channel (rsp_chan): oct_u/oct_v, unorm
// OUT_BITS wide, one response per request, in request order. a zero vector
// encodes as all ones on both coordinates. any nonzero length is accepted.
//
// three stages for norm, fold and numerator, then one divider stage per quotient
// bit. throughput is one request per clock while the receiver does not stall.
//
// valid bits travel with the data through every stage. when the receiver
// stalls, the last stage holds its response and earlier stages keep filling
// until the pipeline is full, so req ready drops only when all stages hold data.
// reset (synchronous) clears every valid bit; no response is pending after it.
`default_nettype none

module octahedral_normal_encode_core import onenc_pkg::*; #(
   parameter int IN_BITS  = 16,
   parameter int OUT_BITS = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   onenc_req_if.sink  req_chan,
   onenc_rsp_if.source rsp_chan
);

   localparam int N_W     = IN_BITS + OUT_BITS + 2;
   localparam int D_W     = IN_BITS + 2;
   localparam int LATENCY = FRONT_STAGES + OUT_BITS;
   localparam int CNT_W   = $clog2(LATENCY + 2);

   logic           front_valid, front_ready;
   logic [N_W-1:0] num_u, num_v;
   logic [D_W-1:0] den;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   onenc_front #(
      .IN_BITS  (IN_BITS),
      .OUT_BITS (OUT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .vec_x     (req_chan.vec_x),
      .vec_y     (req_chan.vec_y),
      .vec_z     (req_chan.vec_z),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .num_u     (num_u),
      .num_v     (num_v),
      .den       (den)
   );

   onenc_div #(
      .IN_BITS  (IN_BITS),
      .OUT_BITS (OUT_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .num_u     (num_u),
      .num_v     (num_v),
      .den       (den),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .quo_u     (rsp_chan.oct_u),
      .quo_v     (rsp_chan.oct_v)
   );

   // requests in flight
   assign cnt_in = cnt_ff + CNT_W'(req_chan.valid && req_chan.ready)
                          - CNT_W'(rsp_chan.valid && rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_only_from_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("request side stalled without response backpressure");

   a_num_u_range: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (num_u[N_W-1:OUT_BITS] < den) || (den == '0 && num_u == '0))
      else $error("u numerator out of divider range");

   a_num_v_range: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (num_v[N_W-1:OUT_BITS] < den) || (den == '0 && num_v == '0))
      else $error("v numerator out of divider range");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(LATENCY)) && (!rsp_chan.valid || cnt_ff != '0))
      else $error("pipeline occupancy inconsistent with handshakes");
`endif

endmodule

`default_nettype wire

### hdl/onenc_front.sv
// front end: magnitudes and l1 norm, hemisphere fold, divider numerator
// uses onenc_pkg for its stage count; feeds onenc_div
`default_nettype none

module onenc_front import onenc_pkg::*; #(
   parameter int IN_BITS  = 16,
   parameter int OUT_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output      logic                           in_ready,
   input  wire logic signed [IN_BITS-1:0]      vec_x,
   input  wire logic signed [IN_BITS-1:0]      vec_y,
   input  wire logic signed [IN_BITS-1:0]      vec_z,
   output      logic                           out_valid,
   input  wire logic                           out_ready,
   output      logic [IN_BITS+OUT_BITS+1:0]    num_u,
   output      logic [IN_BITS+OUT_BITS+1:0]    num_v,
   output      logic [IN_BITS+1:0]             den
);

   localparam int M_W = IN_BITS + 1;
   localparam int P_W = IN_BITS + 2;
   localparam int N_W = IN_BITS + OUT_BITS + 2;

   logic                v_ff [FRONT_STAGES];
   logic [FRONT_STAGES:0] rdy;

   // stage 1: magnitudes, norm, signs
   logic [IN_BITS-1:0] ax_in, ay_in, az_in, ax_ff, ay_ff;
   logic [M_W-1:0]     m1_in, m1_ff;
   logic               sx_ff, sy_ff, zpos_in, zpos_ff;

   // stage 2: p = m + a, in [0, 2m]
   logic [P_W-1:0]     pu_in, pv_in, pu_ff, pv_ff;
   logic [M_W-1:0]     m2_ff;

   // stage 3: numerator (2^n - 1) * p + m and divisor 2m
   logic [N_W-1:0]     nu_in, nv_in, nu_ff, nv_ff;
   logic [P_W-1:0]     den_in, den_ff;

   assign rdy[FRONT_STAGES] = out_ready;
   for (genvar j = 0; j < FRONT_STAGES; j++) begin : g_rdy
      assign rdy[j] = !v_ff[j] || rdy[j+1];
   end
   assign in_ready = rdy[0];

   always_comb begin
      ax_in   = vec_x[IN_BITS-1] ? IN_BITS'(~vec_x + 1'b1) : IN_BITS'(vec_x);
      ay_in   = vec_y[IN_BITS-1] ? IN_BITS'(~vec_y + 1'b1) : IN_BITS'(vec_y);
      az_in   = vec_z[IN_BITS-1] ? IN_BITS'(~vec_z + 1'b1) : IN_BITS'(vec_z);
      m1_in   = M_W'(ax_in) + M_W'(ay_in) + M_W'(az_in);
      zpos_in = !vec_z[IN_BITS-1] && (vec_z != '0);
   end

   always_comb begin
      // upper hemisphere projects straight down, lower one folds over the diagonals
      if (zpos_ff) begin
         pu_in = sx_ff ? P_W'(m1_ff) - P_W'(ax_ff) : P_W'(m1_ff) + P_W'(ax_ff);
         pv_in = sy_ff ? P_W'(m1_ff) - P_W'(ay_ff) : P_W'(m1_ff) + P_W'(ay_ff);
      end else begin
         pu_in = sx_ff ? P_W'(ay_ff) : {m1_ff, 1'b0} - P_W'(ay_ff);
         pv_in = sy_ff ? P_W'(ax_ff) : {m1_ff, 1'b0} - P_W'(ax_ff);
      end
   end

   always_comb begin
      nu_in  = {pu_ff, {OUT_BITS{1'b0}}} - N_W'(pu_ff) + N_W'(m2_ff);
      nv_in  = {pv_ff, {OUT_BITS{1'b0}}} - N_W'(pv_ff) + N_W'(m2_ff);
      den_in = {m2_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
         v_ff[1] <= 1'b0;
         v_ff[2] <= 1'b0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         if (rdy[1]) v_ff[1] <= v_ff[0];
         if (rdy[2]) v_ff[2] <= v_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         m1_ff   <= m1_in;
         sx_ff   <= vec_x[IN_BITS-1];
         sy_ff   <= vec_y[IN_BITS-1];
         zpos_ff <= zpos_in;
      end
      if (rdy[1] && v_ff[0]) begin
         pu_ff <= pu_in;
         pv_ff <= pv_in;
         m2_ff <= m1_ff;
      end
      if (rdy[2] && v_ff[1]) begin
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
         den_ff <= den_in;
      end
   end

   assign out_valid = v_ff[FRONT_STAGES-1];
   assign num_u     = nu_ff;
   assign num_v     = nv_ff;
   assign den       = den_ff;

endmodule

`default_nettype wire

### hdl/onenc_div.sv
// pipelined restoring divider, one quotient bit per stage for both coordinates
// standalone; takes numerator and divisor from onenc_front
`default_nettype none

module onenc_div #(
   parameter int IN_BITS  = 16,
   parameter int OUT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire logic [IN_BITS+OUT_BITS+1:0] num_u,
   input  wire logic [IN_BITS+OUT_BITS+1:0] num_v,
   input  wire logic [IN_BITS+1:0]          den,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      logic [OUT_BITS-1:0]         quo_u,
   output      logic [OUT_BITS-1:0]         quo_v
);

   localparam int D_W = IN_BITS + 2;
   localparam int Q   = OUT_BITS;
   localparam int N_W = IN_BITS + OUT_BITS + 2;

   logic            v_ff  [Q];
   logic [Q:0]      rdy;
   logic [D_W-1:0]  ru_ff [Q];
   logic [D_W-1:0]  rv_ff [Q];
   logic [D_W-1:0]  d_ff  [Q];
   // low numerator bits shift out the top while quotient bits shift in below
   logic [Q-1:0]    wu_ff [Q];
   logic [Q-1:0]    wv_ff [Q];

   assign rdy[Q]   = out_ready;
   assign in_ready = rdy[0];

   for (genvar j = 0; j < Q; j++) begin : g_stage
      logic           pv;
      logic [D_W-1:0] ru_prev, rv_prev, d_prev;
      logic [Q-1:0]   wu_prev, wv_prev;
      logic [D_W:0]   tu, tv;
      logic           geu, gev;
      logic [D_W-1:0] ru_in, rv_in;
      logic [Q-1:0]   wu_in, wv_in;

      if (j == 0) begin : g_first
         assign pv      = in_valid;
         assign ru_prev = num_u[N_W-1:Q];
         assign rv_prev = num_v[N_W-1:Q];
         assign wu_prev = num_u[Q-1:0];
         assign wv_prev = num_v[Q-1:0];
         assign d_prev  = den;
      end else begin : g_next
         assign pv      = v_ff[j-1];
         assign ru_prev = ru_ff[j-1];
         assign rv_prev = rv_ff[j-1];
         assign wu_prev = wu_ff[j-1];
         assign wv_prev = wv_ff[j-1];
         assign d_prev  = d_ff[j-1];
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      // a zero divisor only comes with a zero numerator and yields all ones
      always_comb begin
         tu    = {ru_prev, wu_prev[Q-1]};
         tv    = {rv_prev, wv_prev[Q-1]};
         geu   = tu >= {1'b0, d_prev};
         gev   = tv >= {1'b0, d_prev};
         ru_in = geu ? D_W'(tu - {1'b0, d_prev}) : tu[D_W-1:0];
         rv_in = gev ? D_W'(tv - {1'b0, d_prev}) : tv[D_W-1:0];
         wu_in = {wu_prev[Q-2:0], geu};
         wv_in = {wv_prev[Q-2:0], gev};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j] && pv) begin
            ru_ff[j] <= ru_in;
            rv_ff[j] <= rv_in;
            wu_ff[j] <= wu_in;
            wv_ff[j] <= wv_in;
            d_ff[j]  <= d_prev;
         end
      end
   end

   assign out_valid = v_ff[Q-1];
   assign quo_u     = wu_ff[Q-1];
   assign quo_v     = wv_ff[Q-1];

endmodule

`default_nettype wire

### tb/sv/octahedral_normal_encode_checker.sv
// response checker for the octahedral normal encoder
// watches both channels, predicts each encoding and compares it in order
// depends on hdl/onenc_ifs.sv for the channel interfaces
`default_nettype none

module octahedral_normal_encode_checker (
   input  wire logic clock,
   input  wire logic reset,
   onenc_req_if      req_mon,
   onenc_rsp_if      rsp_mon,
   output int        mismatch_count,
   output int        pending_count
);

   localparam longint UNORM_MAX = 65535;

   typedef struct packed {
      logic [15:0] oct_u;
      logic [15:0] oct_v;
   } oct_pair_type;

   oct_pair_type awaited_codes[$];

   // round-half-up of the remapped coordinate, done in integers
   function automatic logic [15:0] quantize_coord(longint a, longint m);
      longint num;
      longint q;
      num = UNORM_MAX * (m + a) + m;
      q = num / (2 * m);
      if (q > UNORM_MAX) begin
         q = UNORM_MAX;
      end
      return q[15:0];
   endfunction

   function automatic oct_pair_type encode_direction(logic signed [15:0] x,
                                                     logic signed [15:0] y,
                                                     logic signed [15:0] z);
      longint sx, sy, sz, ax, ay, az, m, au, av;
      oct_pair_type code;
      sx = x;
      sy = y;
      sz = z;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      az = (sz < 0) ? -sz : sz;
      m = ax + ay + az;
      if (m == 0) begin
         code.oct_u = 16'hFFFF;
         code.oct_v = 16'hFFFF;
         return code;
      end
      if (sz > 0) begin
         au = sx;
         av = sy;
      end else begin
         // lower hemisphere folds over the diagonals, zero counts as positive
         au = (sx >= 0) ? (m - ay) : -(m - ay);
         av = (sy >= 0) ? (m - ax) : -(m - ax);
      end
      code.oct_u = quantize_coord(au, m);
      code.oct_v = quantize_coord(av, m);
      return code;
   endfunction

   always @(posedge clock) begin
      oct_pair_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_codes.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("unexpected response u=%h v=%h", rsp_mon.oct_u, rsp_mon.oct_v);
               end
            end else begin
               want = awaited_codes.pop_front();
               if (rsp_mon.oct_u !== want.oct_u || rsp_mon.oct_v !== want.oct_v) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("mismatch: expected u=%h v=%h, got u=%h v=%h",
                              want.oct_u, want.oct_v, rsp_mon.oct_u, rsp_mon.oct_v);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_codes.push_back(encode_direction(req_mon.vec_x, req_mon.vec_y,
                                                     req_mon.vec_z));
         end
      end
      pending_count <= awaited_codes.size();
   end

endmodule

`default_nettype wire

### tb/sv/octahedral_normal_encode_core_test.sv
// testbench top for the octahedral normal encoder
// drives direction vectors with random gaps and stalls, verdict from the checker
// depends on onenc_pkg, onenc_ifs, the core and octahedral_normal_encode_checker
`default_nettype none

module octahedral_normal_encode_core_test;
   import onenc_pkg::FRONT_STAGES;

   localparam int VECTORS_PER_PHASE = 550;

   logic clock;
   logic reset;
   int   send_gap_pct;
   int   rsp_stall_pct;
   int   mismatch_count;
   int   pending_count;

   onenc_req_if #(.IN_BITS(16))  req_chan ();
   onenc_rsp_if #(.OUT_BITS(16)) rsp_chan ();

   octahedral_normal_encode_core #(.IN_BITS(16), .OUT_BITS(16)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   octahedral_normal_encode_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_vector(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.vec_x <= x;
      req_chan.vec_y <= y;
      req_chan.vec_z <= z;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // mix of full-range, tiny, zero and extreme components
   function automatic logic signed [15:0] pick_component();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         5, 6: return 16'($signed($urandom_range(64)) - 32);
         7: return 16'sd0;
         8: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         9: begin
            if ($urandom_range(1)) begin
               return 16'sd1 <<< $urandom_range(14);
            end else begin
               return -(16'sd1 <<< $urandom_range(15));
            end
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_phase(input int count);
      logic signed [15:0] x, y, z;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(39) == 0) begin
            x = '0;
            y = '0;
            z = '0;
         end else begin
            x = pick_component();
            y = pick_component();
            z = pick_component();
         end
         send_vector(x, y, z);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.vec_x = '0;
      req_chan.vec_y = '0;
      req_chan.vec_z = '0;
      send_gap_pct = 11;
      rsp_stall_pct = 74;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero vector, axis extremes, lower fold with zero signs, non-unit lengths
      send_vector(16'sd0, 16'sd0, 16'sd0);
      send_vector(16'sh7FFF, 16'sd0, 16'sd0);
      send_vector(16'sh8000, 16'sd0, 16'sd0);
      send_vector(16'sd0, 16'sh7FFF, 16'sd0);
      send_vector(16'sd0, 16'sh8000, 16'sd0);
      send_vector(16'sd0, 16'sd0, 16'sh7FFF);
      send_vector(16'sd0, 16'sd0, 16'sh8000);
      send_vector(16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_vector(16'sh8000, 16'sh7FFF, 16'sh8000);
      send_vector(16'sh7FFF, 16'sh8000, 16'sd1);
      send_vector(16'sd0, -16'sd100, -16'sd200);
      send_vector(-16'sd300, 16'sd0, -16'sd5);
      send_vector(16'sd0, 16'sd0, -16'sd1);
      send_vector(16'sd1, 16'sd1, 16'sd1);
      send_vector(-16'sd1, 16'sd0, 16'sd0);
      send_vector(16'sd1, -16'sd1, -16'sd1);
      send_vector(16'sd23170, -16'sd23170, 16'sd0);
      send_vector(-16'sd18918, 16'sd18918, -16'sd18918);
      send_vector(16'sd18918, 16'sd18918, 16'sd18918);
      send_vector(16'sd1, 16'sd0, 16'sh8000);

      send_random_phase(VECTORS_PER_PHASE);
      send_gap_pct = 74;
      rsp_stall_pct = 11;
      send_random_phase(VECTORS_PER_PHASE);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      send_random_phase(VECTORS_PER_PHASE);
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (FRONT_STAGES + 16 + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
